// File: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// shared types and constants for the length prefix deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } t_kind;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register map
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_TIMEOUT_MS = 4'd1;

    localparam logic [31:0] MAX_FRAME_LEN_RST      = 32'd65536;
    localparam logic [15:0] PARTIAL_TIMEOUT_MS_RST = 16'd1000;
    localparam logic [15:0] TICKS_SAT              = 16'hFFFF;

    typedef struct packed {
        logic [31:0] max_frame_len;
        logic [15:0] partial_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       valid;
        t_kind      result_kind;
        logic [7:0] payload_byte;
        logic       frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/lpd_if.sv
// ----------------------------------------------------------------------------
// lpd interfaces
// request, result and configuration channels of the deframer
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface lpd_res_if;
    logic              valid;
    logic              ready;
    lpd_pkg::t_kind    result_kind;
    logic [7:0]        payload_byte;
    logic              frame_last;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_last, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_last, output ready);
endinterface

interface lpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpd_pkg::CFG_IDX_W-1:0]   index;
    logic [31:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpd_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_cfg_regs (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lpd_cfg_if.sink        i_cfg,
    output lpd_pkg::t_cfg  o_cfg
);
    import lpd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_len      <= MAX_FRAME_LEN_RST;
            r_cfg.partial_timeout_ms <= PARTIAL_TIMEOUT_MS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MAX_FRAME_LEN: begin
                    r_cfg.max_frame_len <= i_cfg.data;
                end
                REG_PARTIAL_TIMEOUT_MS: begin
                    r_cfg.partial_timeout_ms <= i_cfg.data[15:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/lpd_core.sv
// ----------------------------------------------------------------------------
// lpd_core
// frame state and combinational next-state / result logic
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_core #(
    parameter int PREFIX_BYTES = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  lpd_pkg::t_item   i_item,
    input  lpd_pkg::t_cfg    i_cfg,
    output lpd_pkg::t_result o_result
);
    import lpd_pkg::*;

    localparam int SH_W  = (PREFIX_BYTES > 1) ? (PREFIX_BYTES - 1) * 8 : 8;
    localparam int LEN_W = PREFIX_BYTES * 8;
    localparam int CNT_W = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PREFIX_BYTES - 1);

    logic [SH_W-1:0]  r_shift,     n_shift;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [31:0]      r_remaining, n_remaining;
    logic             r_in_payload, n_in_payload;
    logic             r_timer_run, n_timer_run;
    logic [15:0]      r_ticks,     n_ticks;
    logic             r_halted,    n_halted;

    logic [LEN_W-1:0] w_len;
    logic [63:0]      w_len64;
    logic             w_oversize;
    t_result          w_res;

    // full length once the final prefix byte arrives
    assign w_len      = LEN_W'({r_shift, i_item.data_byte});
    assign w_len64    = 64'(w_len);
    assign w_oversize = (|w_len64[63:32]) || (w_len64[31:0] > i_cfg.max_frame_len);

    always_comb begin
        n_shift      = r_shift;
        n_count      = r_count;
        n_remaining  = r_remaining;
        n_in_payload = r_in_payload;
        n_timer_run  = r_timer_run;
        n_ticks      = r_ticks;
        n_halted     = r_halted;
        w_res        = '0;
        w_res.result_kind = KIND_PAYLOAD;

        if (!r_halted) begin
            if (i_item.req_type == REQ_TICK) begin
                if (r_timer_run) begin
                    n_ticks = (r_ticks == TICKS_SAT) ? r_ticks : r_ticks + 16'd1;
                    if (n_ticks >= i_cfg.partial_timeout_ms) begin
                        n_halted          = 1'b1;
                        w_res.valid       = 1'b1;
                        w_res.result_kind = KIND_TIMEOUT;
                    end
                end
            end else if (r_in_payload) begin
                w_res.valid        = 1'b1;
                w_res.result_kind  = KIND_PAYLOAD;
                w_res.payload_byte = i_item.data_byte;
                if (r_remaining == 32'd1) begin
                    w_res.frame_last = 1'b1;
                    n_remaining      = '0;
                    n_in_payload     = 1'b0;
                    n_timer_run      = 1'b0;
                    n_ticks          = '0;
                end else begin
                    n_remaining = r_remaining - 32'd1;
                end
            end else begin
                // prefix byte
                if (!r_timer_run) begin
                    n_timer_run = 1'b1;
                    n_ticks     = '0;
                end
                if (r_count != CNT_LAST) begin
                    n_shift = SH_W'({r_shift, i_item.data_byte});
                    n_count = r_count + CNT_W'(1);
                end else if (w_oversize) begin
                    n_halted          = 1'b1;
                    w_res.valid       = 1'b1;
                    w_res.result_kind = KIND_OVERSIZE;
                end else if (w_len64 == 64'd0) begin
                    n_shift           = '0;
                    n_count           = '0;
                    n_timer_run       = 1'b0;
                    n_ticks           = '0;
                    w_res.valid       = 1'b1;
                    w_res.result_kind = KIND_EMPTY;
                    w_res.frame_last  = 1'b1;
                end else begin
                    n_shift      = '0;
                    n_count      = '0;
                    n_remaining  = w_len64[31:0];
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= '0;
            r_count      <= '0;
            r_remaining  <= '0;
            r_in_payload <= 1'b0;
            r_timer_run  <= 1'b0;
            r_ticks      <= '0;
            r_halted     <= 1'b0;
        end else if (i_en) begin
            r_shift      <= n_shift;
            r_count      <= n_count;
            r_remaining  <= n_remaining;
            r_in_payload <= n_in_payload;
            r_timer_run  <= n_timer_run;
            r_ticks      <= n_ticks;
            r_halted     <= n_halted;
        end
    end

    // once halted, nothing more comes out
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !w_res.valid)
        else $error("result produced while halted");

    // halt only follows an error result
    a_halt_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> $past(i_en && w_res.valid &&
            (w_res.result_kind == KIND_OVERSIZE || w_res.result_kind == KIND_TIMEOUT)))
        else $error("halt without error result");

    // a payload phase always has bytes left to pass
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_remaining != 32'd0))
        else $error("payload phase with zero remaining");

    // the deadline runs through every payload phase
    a_timer_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_timer_run)
        else $error("payload phase without running deadline");

endmodule

`default_nettype wire

// File: rtl/length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer
// splits a byte stream into frames led by a big-endian length prefix
// ----------------------------------------------------------------------------
// Each request beat is either a received byte or a one millisecond tick. The
// first PREFIX_BYTES bytes of a frame form a big-endian length; a length above
// max_frame_len gives an oversize error, a zero length gives one empty-frame
// result, any other length passes that many following bytes out as payload
// beats with frame_last on the final one. The first prefix byte starts a
// deadline of partial_timeout_ms ticks that runs until the frame completes;
// expiry gives a timeout error. After either error the block drops every beat
// until reset. Throughput is one request beat per clock cycle while the
// result side keeps up; each beat passes through the request register in
// front of the combinational frame logic and the result register behind it.
// Configuration writes are taken at any time but must only be made while the
// block is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer #(
    parameter int PREFIX_BYTES = 4
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lpd_req_if.sink   i_req,
    lpd_res_if.source o_res,
    lpd_cfg_if.sink   i_cfg
);
    import lpd_pkg::*;

    // request register
    logic    r_in_valid;
    t_item   r_item;

    // result register
    logic    r_out_valid;
    t_result r_out;

    t_cfg    w_cfg;
    t_result w_result;
    t_item   w_item;
    logic    w_out_free;   // result register can take a new value
    logic    w_proc;       // held request is processed this cycle

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_proc      = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;

    assign w_item.req_type  = i_req.req_type;
    assign w_item.data_byte = i_req.data_byte;

    lpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    lpd_core #(
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_proc),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_free) begin
                // items that cause no result leave the register empty
                r_out_valid <= w_proc && w_result.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= w_item;
        end
        if (w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_kind  = r_out.result_kind;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.frame_last   = r_out.frame_last;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the length prefix deframer
// ----------------------------------------------------------------------------
// A scoreboard model of the deframer predicts every result beat. The run
// starts with a short table of hand-written beats, some with their results
// typed in. It then goes through several limit settings with random frames
// and ticks on both sides. Because an error halts the block until reset, the
// run ends with one error case picked at random, followed by beats that must
// be dropped. Both channels stall at random.
// ----------------------------------------------------------------------------

module testbench;
    import lpd_pkg::*;

    localparam int PREFIX_BYTES  = 4;
    localparam int PFX_W         = 8 * (PREFIX_BYTES - 1);
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 250;
    localparam int N_PHASES      = 6;
    localparam int N_FIXED       = 4;
    localparam int N_DIRECTED    = 25;
    localparam int NOISE_ITEMS   = 24;

    // index past the end of the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_beat;

    // one row of the directed table; typed rows carry their own result
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       typed;
        logic       has_res;
        t_kind      kind;
        logic [7:0] exp_byte;
        logic       exp_last;
    } t_row;

    // ways the run is brought to its final halt
    typedef enum int {
        END_OVERSIZE_MIN,
        END_OVERSIZE_MAX,
        END_TIMEOUT_ZERO,
        END_TIMEOUT_LATE
    } t_ending;

    // directed beats with the reset limits in force
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        // tick with no frame open is ignored
        '{REQ_TICK, 8'hFF, 1'b1, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        // zero length gives one empty frame
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b1, 1'b1, KIND_EMPTY,   8'h00, 1'b1},
        // one byte frame carrying all ones
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'hFF, 1'b1, 1'b1, KIND_PAYLOAD, 8'hFF, 1'b1},
        // two byte frame with ticks in the prefix and the payload
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_TICK, 8'h5A, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h02, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b1, 1'b1, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_TICK, 8'hA5, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h80, 1'b1, 1'b1, KIND_PAYLOAD, 8'h80, 1'b1},
        // three byte frame, checked by the model
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h03, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'hA5, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h5A, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{REQ_BYTE, 8'h7F, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0}
    };

    // limit settings walked in order: extremes first, then random ones
    localparam logic [31:0] PHASE_MAX [0:N_FIXED-1] =
        '{32'hFFFF_FFFF, 32'd300, 32'd0, 32'd1};
    localparam logic [15:0] PHASE_TIMEOUT [0:N_FIXED-1] =
        '{16'hFFFF, 16'd1, 16'd3, 16'd2};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpd_req_if req_bus ();
    lpd_res_if res_bus ();
    lpd_cfg_if cfg_bus ();

    length_prefix_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scoreboard model of the deframer
    // ------------------------------------------------------------------

    // limits as last written
    logic [31:0]      lim_len;
    logic [15:0]      lim_ticks;
    // frame state
    logic [PFX_W-1:0] pfx_acc;
    logic [2:0]       pfx_cnt;
    logic [31:0]      frm_len;
    logic [31:0]      frm_done;
    logic             payload_on;
    logic             deadline_on;
    logic [15:0]      tick_count;
    logic             stopped;

    // result beats still owed by the block, oldest first
    t_beat pending[$];

    int mismatches  = 0;
    int beats_seen  = 0;
    int items_sent  = 0;
    int quiet_count = 0;
    int send_burst  = 0;
    bit send_eager  = 1'b0;

    function automatic void clear_frame();
        pfx_acc     = '0;
        pfx_cnt     = '0;
        frm_len     = '0;
        frm_done    = '0;
        payload_on  = 1'b0;
        deadline_on = 1'b0;
        tick_count  = '0;
    endfunction

    // advance the model by one beat; returns 1 when a result is due
    function automatic bit deframe_predict(input t_item it, output t_beat res);
        logic [31:0] len;
        res = '{KIND_PAYLOAD, 8'h00, 1'b0};
        if (stopped) return 1'b0;

        if (it.req_type == REQ_TICK) begin
            // ticks only matter while a frame is open
            if (!deadline_on) return 1'b0;
            if (tick_count != TICKS_SAT) tick_count++;
            if (tick_count >= lim_ticks) begin
                stopped  = 1'b1;
                res.kind = KIND_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end

        if (payload_on) begin
            frm_done++;
            res.data = it.data_byte;
            if (frm_done >= frm_len) begin
                clear_frame();
                res.last = 1'b1;
            end
            return 1'b1;
        end

        // prefix byte; the first one opens the deadline
        if (!deadline_on) begin
            deadline_on = 1'b1;
            tick_count  = '0;
        end
        if (pfx_cnt + 1 < PREFIX_BYTES) begin
            pfx_acc = {pfx_acc[PFX_W-9:0], it.data_byte};
            pfx_cnt++;
            return 1'b0;
        end
        len = {pfx_acc, it.data_byte};
        if (len > lim_len) begin
            stopped  = 1'b1;
            res.kind = KIND_OVERSIZE;
            return 1'b1;
        end
        if (len == 0) begin
            clear_frame();
            res.kind = KIND_EMPTY;
            res.last = 1'b1;
            return 1'b1;
        end
        pfx_acc    = '0;
        pfx_cnt    = '0;
        frm_len    = len;
        frm_done   = '0;
        payload_on = 1'b1;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // drive one request beat after a random gap and record what it owes
    task automatic send_item(input logic rt, input logic [7:0] b, input logic typed,
                             input logic has_res, input t_beat typed_beat);
        int    gap;
        t_item it;
        t_beat got;
        bit    produced;
        // stretches with no gaps at all now and then
        if (send_burst == 0) begin
            send_eager = ($urandom_range(0, 2) == 0);
            send_burst = $urandom_range(20, 80);
        end
        send_burst--;
        gap = send_eager ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= rt;
        req_bus.data_byte <= b;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        // beat taken at this edge
        items_sent++;
        it.req_type  = rt;
        it.data_byte = b;
        produced = deframe_predict(it, got);
        if (typed) begin
            if (has_res) pending.push_back(typed_beat);
        end else if (produced) begin
            pending.push_back(got);
        end
    endtask

    task automatic send_plain(input logic rt, input logic [7:0] b);
        send_item(rt, b, 1'b0, 1'b0, '0);
    endtask

    // hold the sender until every owed result is back and the pipe is empty
    task automatic wait_idle();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == REG_MAX_FRAME_LEN) lim_len = val;
        else if (idx == REG_PARTIAL_TIMEOUT_MS) lim_ticks = val[15:0];
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly short frames, sometimes empty, sometimes right at the limit
    function automatic logic [31:0] pick_len();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (lim_len == 0 || pick == 0) return 32'd0;
        if (pick == 1)
            return (lim_len <= 32'd300) ? lim_len : 32'($urandom_range(17, 300));
        if (lim_len < 32'd16) return 32'($urandom_range(1, int'(lim_len)));
        return 32'($urandom_range(1, 16));
    endfunction

    // one well-formed frame with ticks that stay inside the deadline
    task automatic send_frame();
        logic [31:0] len;
        logic [7:0]  b;
        int unsigned pick;
        // ticks between frames are dropped by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_plain(REQ_TICK, 8'($urandom));
        len = pick_len();
        for (int i = 0; i < PREFIX_BYTES + int'(len); i++) begin
            if ($urandom_range(0, 5) == 0
                && (!deadline_on || int'(tick_count) + 1 < int'(lim_ticks)))
                send_plain(REQ_TICK, 8'($urandom));
            if (i < PREFIX_BYTES) begin
                b = len[8*(PREFIX_BYTES-1-i) +: 8];
            end else begin
                pick = $urandom_range(0, 7);
                b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            end
            send_plain(REQ_BYTE, b);
        end
    endtask

    // last case of the run: the block halts for good after it
    task automatic end_with_error();
        t_ending     ending;
        logic [15:0] limit;
        ending = t_ending'($urandom_range(0, 3));
        wait_idle();
        case (ending)
            END_OVERSIZE_MIN: begin
                // length one against a zero limit
                write_reg(REG_MAX_FRAME_LEN, 32'd0);
                repeat (PREFIX_BYTES - 1) send_plain(REQ_BYTE, 8'h00);
                send_item(REQ_BYTE, 8'h01, 1'b1, 1'b1,
                          t_beat'{KIND_OVERSIZE, 8'h00, 1'b0});
            end
            END_OVERSIZE_MAX: begin
                // all-ones length against any smaller limit
                write_reg(REG_MAX_FRAME_LEN, $urandom & 32'hFFFF_FFFE);
                repeat (PREFIX_BYTES - 1) send_plain(REQ_BYTE, 8'hFF);
                send_item(REQ_BYTE, 8'hFF, 1'b1, 1'b1,
                          t_beat'{KIND_OVERSIZE, 8'h00, 1'b0});
            end
            END_TIMEOUT_ZERO: begin
                // zero timeout: first tick after a prefix byte expires
                write_reg(REG_PARTIAL_TIMEOUT_MS, {16'($urandom), 16'd0});
                send_plain(REQ_BYTE, 8'($urandom));
                send_item(REQ_TICK, 8'($urandom), 1'b1, 1'b1,
                          t_beat'{KIND_TIMEOUT, 8'h00, 1'b0});
            end
            default: begin
                // random bytes and ticks until the deadline runs out
                limit = 16'($urandom_range(2, 20));
                write_reg(REG_MAX_FRAME_LEN, 32'hFFFF_FFFF);
                write_reg(REG_PARTIAL_TIMEOUT_MS, {16'($urandom), limit});
                while (!stopped) send_plain(1'($urandom), 8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] max_len;
        logic [15:0] timeout;
        int          phase_start;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_BYTE;
        req_bus.data_byte = 8'h00;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_MAX_FRAME_LEN;
        cfg_bus.data      = 32'd0;
        lim_len   = MAX_FRAME_LEN_RST;
        lim_ticks = PARTIAL_TIMEOUT_MS_RST;
        stopped   = 1'b0;
        clear_frame();

        // reset held, then released on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table with the reset limits
        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED[r].req_type, DIRECTED[r].data_byte, DIRECTED[r].typed,
                      DIRECTED[r].has_res,
                      t_beat'{DIRECTED[r].kind, DIRECTED[r].exp_byte,
                              DIRECTED[r].exp_last});

        // write to an unmapped index, must change nothing
        wait_idle();
        write_reg(REG_UNMAPPED, $urandom);

        // random frames under several limit settings
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_FIXED) begin
                max_len = PHASE_MAX[p];
                timeout = PHASE_TIMEOUT[p];
            end else begin
                max_len = 32'($urandom_range(1, 400));
                timeout = 16'($urandom_range(2, 60));
            end
            wait_idle();
            write_reg(REG_MAX_FRAME_LEN, max_len);
            // upper bits of the timeout write are junk on purpose
            write_reg(REG_PARTIAL_TIMEOUT_MS, {16'($urandom), timeout});
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_frame();
        end

        end_with_error();

        // halted: everything from here on is dropped
        repeat (NOISE_ITEMS) send_plain(1'($urandom), 8'($urandom));

        wait_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure with stall-free stretches
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int burst;
        bit eager;
        burst = 0;
        eager = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            if (burst == 0) begin
                eager = ($urandom_range(0, 2) == 0);
                burst = $urandom_range(20, 80);
            end
            burst--;
            stall = eager ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                @(negedge i_clk);
                res_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_bus.valid && res_bus.ready)) @(posedge i_clk);
        end
    end

    // compare each result beat with the oldest owed one
    always @(posedge i_clk) begin : check_results
        t_beat want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            beats_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("beat %0d: result with nothing owed, kind %0d",
                                          beats_seen, res_bus.result_kind));
            end else begin
                want = pending.pop_front();
                if (res_bus.result_kind !== want.kind)
                    report_mismatch($sformatf("beat %0d: kind %0d, want %0d", beats_seen,
                                              res_bus.result_kind, want.kind));
                if (res_bus.payload_byte !== want.data)
                    report_mismatch($sformatf("beat %0d: byte %02h, want %02h", beats_seen,
                                              res_bus.payload_byte, want.data));
                if (res_bus.frame_last !== want.last)
                    report_mismatch($sformatf("beat %0d: last %0b, want %0b", beats_seen,
                                              res_bus.frame_last, want.last));
            end
        end
    end

    // watchdog: too long with no beat on any channel ends the run
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_count <= 0;
        end else if (quiet_count == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

endmodule
